/* hw/rtl/mrrn_pkg.sv */
`default_nettype none

package mrrn_pkg;

    // Node ids and message fields are fixed by the 4-bit id and 16-bit stamp fields.
    localparam int ID_W      = 4;
    localparam int STAMP_W   = 16;
    localparam int COUNT_W   = 5;
    localparam int NODE_IDS  = 1 << ID_W;
    localparam int DEF_MAX_NODES = 16;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Configuration register indexes.
    localparam logic REG_OWN_ID     = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_REQUEST         = 2'd0,
        OP_RECEIVE_REQUEST = 2'd1,
        OP_RECEIVE_REPLY   = 2'd2,
        OP_RELEASE         = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_ENTER   = 2'd2
    } msg_kind_t;

    // Control part of one job handed from the front to the back. A single job
    // gives exactly one beat to dest; otherwise one beat goes to each set bit
    // of the job mask, lowest first.
    typedef struct packed {
        msg_kind_t           kind;
        logic                single;
        logic [ID_W-1:0]     dest;
        logic [STAMP_W-1:0]  stamp;
    } job_ctl_t;

    typedef struct packed {
        logic requesting;
        logic in_critical;
        logic awaiting_none;
    } front_status_t;

    function automatic logic [STAMP_W-1:0] bump_stamp(input logic [STAMP_W-1:0] base);
        bump_stamp = (base == STAMP_MAX) ? base : base + STAMP_W'(1);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mutex_request_reply_node.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: opcode; tdata: sender, msg_stamp
// m_*       out        m_tvalid/m_tready  tuser: msg_kind; tdata: dest, stamp; tlast
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each event is taken on the edge where s_tvalid and s_tready are both high; the node state is updated at that edge.
// A request or release gives up to 15 beats, one per cycle while m_tready is high:
// node_count - 1, or node_count when own_id is not among the nodes in use. The back
// end loads a job from the queue only when the previous job's beats are all out, and
// registers each beat in its output slot, so a job's first beat follows its loading.
// Reset is synchronous and active low; it clears all node state and the queue.
// A two-entry job queue lets the front take events while the back drains;
// s_tready drops only while the job queue is full; configuration is always taken.

module mutex_request_reply_node import mrrn_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [3:0] sender, [19:4] msg_stamp, [23:20] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] dest, [19:4] stamp, [23:20] zero
    output logic [1:0]       m_tuser,   // [1:0] msg_kind
    output logic             m_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data
);

    // Masks cover the node ids that can be in use at all.
    localparam int MASK_W = (MAX_NODES < NODE_IDS) ? MAX_NODES : NODE_IDS;
    localparam int JOB_W  = $bits(job_ctl_t) + MASK_W;

    logic [ID_W-1:0]    own_id_reg;
    logic [COUNT_W-1:0] node_count_reg;

    // Configuration writes land immediately.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg     <= '0;
            node_count_reg <= NODE_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_OWN_ID:     own_id_reg     <= cfg_data[ID_W-1:0];
                REG_NODE_COUNT: node_count_reg <= cfg_data;
                default:        own_id_reg     <= own_id_reg;
            endcase
        end
    end

    logic               in_accept;
    job_ctl_t           push_ctl;
    logic [MASK_W-1:0]  push_mask;
    logic               push;
    logic               q_full;
    logic               q_not_empty;
    logic               pop;
    logic [JOB_W-1:0]   pop_word;
    job_ctl_t           pop_ctl;
    logic [MASK_W-1:0]  pop_mask;
    front_status_t      status;
    msg_kind_t          out_kind;
    logic [ID_W-1:0]    out_dest;
    logic [STAMP_W-1:0] out_stamp;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    mrrn_front #(
        .MASK_W(MASK_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .own_id     (own_id_reg),
        .node_count (node_count_reg),
        .in_accept  (in_accept),
        .in_opcode  (opcode_t'(s_tuser)),
        .in_sender  (s_tdata[3:0]),
        .in_stamp   (s_tdata[19:4]),
        .job_ctl    (push_ctl),
        .job_mask   (push_mask),
        .job_push   (push),
        .status     (status)
    );

    mrrn_queue #(
        .DATA_W(JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctl, push_mask}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_word),
        .not_empty (q_not_empty)
    );

    assign pop_ctl  = pop_word[JOB_W-1:MASK_W];
    assign pop_mask = pop_word[MASK_W-1:0];

    mrrn_back #(
        .MASK_W(MASK_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_ready (q_not_empty),
        .job_ctl   (pop_ctl),
        .job_mask  (pop_mask),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_dest  (out_dest),
        .out_stamp (out_stamp),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_stamp, out_dest};
    assign m_tuser = out_kind;

`ifndef SYNTHESIS
    // The node is only ever in the critical region on behalf of its own request.
    a_crit_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        status.in_critical |-> status.requesting)
        else $error("in critical region without an open request");

    // Entering requires that every awaited reply has come in.
    a_crit_no_awaiting: assert property (@(posedge aclk) disable iff (!aresetn)
        status.in_critical |-> status.awaiting_none)
        else $error("in critical region while replies are still awaited");

    // No beat is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mrrn_front.sv */
`default_nettype none

module mrrn_front import mrrn_pkg::*; #(
    parameter int MASK_W = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [ID_W-1:0]     own_id,
    input  wire logic [COUNT_W-1:0]  node_count,
    input  wire logic                in_accept,
    input  wire opcode_t             in_opcode,
    input  wire logic [ID_W-1:0]     in_sender,
    input  wire logic [STAMP_W-1:0]  in_stamp,
    output job_ctl_t                 job_ctl,
    output logic [MASK_W-1:0]        job_mask,
    output logic                     job_push,
    output front_status_t            status
);

    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [STAMP_W-1:0] req_stamp_reg, req_stamp_next;
    logic               requesting_reg, requesting_next;
    logic               in_critical_reg, in_critical_next;
    logic [MASK_W-1:0]  deferred_reg, deferred_next;
    logic [MASK_W-1:0]  awaiting_reg, awaiting_next;

    logic [COUNT_W-1:0] n_lim;
    logic [MASK_W-1:0]  in_use;
    logic [MASK_W-1:0]  me_bit;
    logic [MASK_W-1:0]  sender_bit;
    logic [MASK_W-1:0]  others;
    logic [MASK_W-1:0]  awaiting_left;
    logic               foreign;
    logic               earlier;
    logic [STAMP_W-1:0] merged;
    logic               job_valid;

    always_comb begin
        n_lim = (node_count > COUNT_W'(MASK_W)) ? COUNT_W'(MASK_W) : node_count;
        for (int i = 0; i < MASK_W; i++) begin
            in_use[i] = (COUNT_W'(i) < n_lim);
        end
        me_bit        = MASK_W'(1) << own_id;
        sender_bit    = MASK_W'(1) << in_sender;
        others        = in_use & ~me_bit;
        awaiting_left = awaiting_reg & ~sender_bit;
        foreign       = (in_sender == own_id) || ({1'b0, in_sender} >= n_lim);
        merged        = bump_stamp((clock_reg > in_stamp) ? clock_reg : in_stamp);
        earlier       = (req_stamp_reg < in_stamp) ||
                        ((req_stamp_reg == in_stamp) && (own_id < in_sender));
    end

    always_comb begin
        clock_next       = clock_reg;
        req_stamp_next   = req_stamp_reg;
        requesting_next  = requesting_reg;
        in_critical_next = in_critical_reg;
        deferred_next    = deferred_reg;
        awaiting_next    = awaiting_reg;
        job_valid        = 1'b0;
        job_ctl.kind     = KIND_REQUEST;
        job_ctl.single   = 1'b0;
        job_ctl.dest     = own_id;
        job_ctl.stamp    = clock_reg;
        job_mask         = others;

        case (in_opcode)
            OP_REQUEST: begin
                if (!requesting_reg && !in_critical_reg) begin
                    requesting_next = 1'b1;
                    req_stamp_next  = clock_reg;
                    awaiting_next   = others;
                    job_valid       = 1'b1;
                    if (others == '0) begin
                        // Alone in the group: enter right away.
                        in_critical_next = 1'b1;
                        job_ctl.kind     = KIND_ENTER;
                        job_ctl.single   = 1'b1;
                    end
                end
            end
            OP_RECEIVE_REQUEST: begin
                if (!foreign) begin
                    clock_next = merged;
                    if (in_critical_reg || (requesting_reg && earlier)) begin
                        deferred_next = deferred_reg | sender_bit;
                    end else begin
                        job_valid      = 1'b1;
                        job_ctl.kind   = KIND_REPLY;
                        job_ctl.single = 1'b1;
                        job_ctl.dest   = in_sender;
                        job_ctl.stamp  = merged;
                    end
                end
            end
            OP_RECEIVE_REPLY: begin
                if (!foreign) begin
                    awaiting_next = awaiting_left;
                    clock_next    = merged;
                    if (requesting_reg && !in_critical_reg && (awaiting_left == '0)) begin
                        // The enter notice carries the clock from before this reply.
                        in_critical_next = 1'b1;
                        job_valid        = 1'b1;
                        job_ctl.kind     = KIND_ENTER;
                        job_ctl.single   = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                clock_next       = bump_stamp(clock_reg);
                requesting_next  = 1'b0;
                in_critical_next = 1'b0;
                awaiting_next    = '0;
                deferred_next    = '0;
                job_valid        = (deferred_reg != '0);
                job_ctl.kind     = KIND_REPLY;
                job_ctl.stamp    = bump_stamp(clock_reg);
                job_mask         = deferred_reg;
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

    assign job_push = in_accept && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg       <= '0;
            req_stamp_reg   <= '0;
            requesting_reg  <= 1'b0;
            in_critical_reg <= 1'b0;
            deferred_reg    <= '0;
            awaiting_reg    <= '0;
        end else if (in_accept) begin
            clock_reg       <= clock_next;
            req_stamp_reg   <= req_stamp_next;
            requesting_reg  <= requesting_next;
            in_critical_reg <= in_critical_next;
            deferred_reg    <= deferred_next;
            awaiting_reg    <= awaiting_next;
        end
    end

    assign status.requesting    = requesting_reg;
    assign status.in_critical   = in_critical_reg;
    assign status.awaiting_none = (awaiting_reg == '0);

endmodule

`default_nettype wire

/* hw/rtl/mrrn_queue.sv */
`default_nettype none

module mrrn_queue import mrrn_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   not_empty
);

    // Two entries are enough for the front to take the next event while the
    // back is still sweeping out the beats of the previous one.
    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mrrn_back.sv */
`default_nettype none

module mrrn_back import mrrn_pkg::*; #(
    parameter int MASK_W = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                job_ready,
    input  wire job_ctl_t            job_ctl,
    input  wire logic [MASK_W-1:0]   job_mask,
    output logic                     job_pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output msg_kind_t                out_kind,
    output logic [ID_W-1:0]          out_dest,
    output logic [STAMP_W-1:0]       out_stamp,
    output logic                     out_last
);

    logic               busy_reg, busy_next;
    job_ctl_t           cur_reg;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [ID_W-1:0]    low_id;
    logic               slot_free;
    logic               fire;
    logic               fire_last;

    logic               ov_reg;
    msg_kind_t          kind_reg;
    logic [ID_W-1:0]    dest_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               last_reg;

    always_comb begin
        low_id = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_id = ID_W'(i);
            end
        end
    end

    assign slot_free = !ov_reg || out_ready;
    assign fire      = busy_reg && slot_free;
    assign mask_next = mask_reg & (mask_reg - MASK_W'(1));
    assign fire_last = cur_reg.single || (mask_next == '0);
    assign job_pop   = !busy_reg && job_ready;

    always_comb begin
        busy_next = busy_reg;
        if (job_pop) begin
            busy_next = 1'b1;
        end else if (fire && fire_last) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (slot_free) begin
                ov_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            cur_reg  <= job_ctl;
            mask_reg <= job_mask;
        end else if (fire) begin
            mask_reg <= mask_next;
        end
        if (fire) begin
            kind_reg  <= cur_reg.kind;
            dest_reg  <= cur_reg.single ? cur_reg.dest : low_id;
            stamp_reg <= cur_reg.stamp;
            last_reg  <= fire_last;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = kind_reg;
    assign out_dest  = dest_reg;
    assign out_stamp = stamp_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    import mrrn_pkg::*;

    // One message the node is expected to put out, in the order it must appear.
    typedef struct {
        msg_kind_t        kind;
        logic [3:0]       dest;
        logic [15:0]      stamp;
        logic             last;
    } node_msg_t;

    logic        aclk;
    logic        aresetn;

    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [3:0] sender, [19:4] msg_stamp, [23:20] zero
    logic [1:0]  s_tuser;   // [1:0] opcode

    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [3:0] dest, [19:4] stamp, [23:20] zero
    logic [1:0]  m_tuser;   // [1:0] msg_kind
    logic        m_tlast;

    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    mutex_request_reply_node dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Cycles to let pass after the last expected beat before the node is
    // considered idle. A job is loaded from a two-deep queue before its beats go out,
    // so this leaves ample margin for events that produce no beats.
    localparam int SETTLE_CYCLES = 8;

    // Mirror of the node: configuration plus protocol state, updated at the
    // very edge where the hardware accepts an event or a register write.
    logic [3:0]  cfg_own;
    logic [4:0]  cfg_count;
    logic [15:0] node_clock;
    logic [15:0] own_req_stamp;
    logic        want_cs;
    logic        in_cs;
    logic [15:0] deferred_bits;
    logic [15:0] awaited_bits;

    node_msg_t   expected_msgs[$];
    int          err_count;
    int          items_sent;
    int          rx_hold;       // long receiver hold-off, counted down per cycle
    logic        steady;        // when set, neither side inserts gaps

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Lamport clock step, held at the top of the 16-bit range.
    function automatic logic [15:0] clock_inc(input logic [15:0] base);
        return (base == 16'hFFFF) ? base : base + 16'd1;
    endfunction

    // Advance the node clock for a message and append the new event's beats to
    // the expected beat stream. Beats of one event are gathered first so the
    // final one can carry the last flag.
    function automatic void predict_event(input opcode_t op, input logic [3:0] snd,
                                          input logic [15:0] mst);
        node_msg_t burst[$];
        node_msg_t msg;
        int        n;
        logic [15:0] seen;

        n = (cfg_count > 5'd16) ? 16 : int'(cfg_count);
        case (op)
            OP_REQUEST: begin
                // A second request while one is open or while inside is dropped.
                if (!want_cs && !in_cs) begin
                    want_cs = 1'b1;
                    own_req_stamp = node_clock;
                    awaited_bits = '0;
                    for (int i = 0; i < n; i++) begin
                        if (i != int'(cfg_own)) begin
                            burst.push_back('{kind: KIND_REQUEST, dest: 4'(i),
                                              stamp: own_req_stamp, last: 1'b0});
                            awaited_bits[i] = 1'b1;
                        end
                    end
                    // With nobody else to ask, the node goes straight in.
                    if (burst.size() == 0) begin
                        in_cs = 1'b1;
                        burst.push_back('{kind: KIND_ENTER, dest: cfg_own,
                                          stamp: node_clock, last: 1'b0});
                    end
                end
            end
            OP_RECEIVE_REQUEST: begin
                if (snd != cfg_own && int'(snd) < n) begin
                    seen = (node_clock > mst) ? node_clock : mst;
                    node_clock = clock_inc(seen);
                    // Our open request wins on a lower stamp, or on a tie with
                    // the lower id; the remote request then waits for release.
                    if (in_cs || (want_cs && (own_req_stamp < mst ||
                            (own_req_stamp == mst && cfg_own < snd)))) begin
                        deferred_bits[snd] = 1'b1;
                    end else begin
                        burst.push_back('{kind: KIND_REPLY, dest: snd,
                                          stamp: node_clock, last: 1'b0});
                    end
                end
            end
            OP_RECEIVE_REPLY: begin
                if (snd != cfg_own && int'(snd) < n) begin
                    awaited_bits[snd] = 1'b0;
                    // The enter notice carries the clock from before this reply.
                    if (want_cs && !in_cs && awaited_bits == '0) begin
                        in_cs = 1'b1;
                        burst.push_back('{kind: KIND_ENTER, dest: cfg_own,
                                          stamp: node_clock, last: 1'b0});
                    end
                    seen = (node_clock > mst) ? node_clock : mst;
                    node_clock = clock_inc(seen);
                end
            end
            default: begin
                // Release also aborts a request that never got in.
                node_clock = clock_inc(node_clock);
                want_cs = 1'b0;
                in_cs = 1'b0;
                awaited_bits = '0;
                for (int i = 0; i < 16; i++) begin
                    if (deferred_bits[i]) begin
                        burst.push_back('{kind: KIND_REPLY, dest: 4'(i),
                                          stamp: node_clock, last: 1'b0});
                    end
                end
                deferred_bits = '0;
            end
        endcase

        for (int j = 0; j < burst.size(); j++) begin
            msg = burst[j];
            msg.last = (j == burst.size() - 1);
            expected_msgs.push_back(msg);
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Monitor: everything is sampled at the rising edge, before the node's own
    // registers move, so prediction and checking see exactly what was accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_OWN_ID) begin
                    cfg_own <= cfg_data[3:0];
                end else begin
                    cfg_count <= cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_event(opcode_t'(s_tuser), s_tdata[3:0], s_tdata[19:4]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_msgs.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, %s %0h dest %0h stamp %0h",
                             $time, "actual kind", m_tuser, m_tdata[3:0], m_tdata[19:4]);
                    err_count++;
                end else begin
                    check_field("msg_kind", int'(expected_msgs[0].kind), int'(m_tuser));
                    check_field("dest", int'(expected_msgs[0].dest), int'(m_tdata[3:0]));
                    check_field("stamp", int'(expected_msgs[0].stamp), int'(m_tdata[19:4]));
                    check_field("last", int'(expected_msgs[0].last), int'(m_tlast));
                    void'(expected_msgs.pop_front());
                end
            end
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, plus the long hold-off that a test can request.
    initial begin
        int rx_gap;
        rx_gap = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_tready = 1'b0;
                rx_gap--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    rx_gap = pick_gap();
                end
            end
        end
    end

    // Offer one event and hold it until the node takes it. Valid stays high
    // afterwards so back-to-back events keep the channel busy; any task that
    // stops sending lowers it at the next falling edge.
    task automatic send_event(input opcode_t op, input logic [3:0] snd,
                              input logic [15:0] mst);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0, mst, snd};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Pause the sender until every expected beat has been seen, then let the
    // node settle. Ends on a falling edge with the mirror up to date.
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_msgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [3:0] own, input logic [4:0] count);
        wait_drain();
        write_reg(REG_OWN_ID, {1'b0, own});
        write_reg(REG_NODE_COUNT, count);
    endtask

    // Remote stamps mostly sit a little ahead of the local clock, sometimes
    // behind it, so the clock keeps moving without running away.
    function automatic logic [15:0] stamp_near();
        int c;
        c = int'(node_clock);
        if ($urandom_range(0, 9) < 4) begin
            return 16'($urandom_range(0, c));
        end
        c = c + $urandom_range(0, 8);
        if (c > 65535) c = 65535;
        return 16'(c);
    endfunction

    // Degenerate node counts: alone, none in use, and an id outside the set.
    task automatic test_lone_node();
        set_config(4'd0, 5'd1);
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RELEASE, 4'd0, 16'd0);

        set_config(4'd15, 5'd0);
        send_event(OP_REQUEST, 4'd15, 16'hFFFF);
        send_event(OP_RECEIVE_REQUEST, 4'd0, 16'd3);
        send_event(OP_RELEASE, 4'd0, 16'd0);

        // Id 5 is not among the single node in use, so it must ask node 0.
        set_config(4'd5, 5'd1);
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RECEIVE_REPLY, 4'd0, 16'd2);
        send_event(OP_RELEASE, 4'd0, 16'd0);
    endtask

    // Tie break on equal stamps, deferral while asking and while inside,
    // ignored senders, a busy request, idle release and an aborted request.
    task automatic test_priority_and_deferral();
        logic [15:0] base;
        set_config(4'd2, 5'd4);
        base = node_clock;
        send_event(OP_REQUEST, 4'hF, 16'hFFFF);
        send_event(OP_RECEIVE_REQUEST, 4'd1, base);          // lower id wins the tie
        send_event(OP_RECEIVE_REQUEST, 4'd3, base);          // we win the tie
        send_event(OP_RECEIVE_REQUEST, 4'd0, base + 16'd50); // our stamp is lower
        send_event(OP_REQUEST, 4'd0, 16'd0);                 // already asking
        send_event(OP_RECEIVE_REPLY, 4'd2, 16'd0);           // from ourselves
        send_event(OP_RECEIVE_REPLY, 4'd9, 16'd0);           // not a node in use
        send_event(OP_RECEIVE_REQUEST, 4'd15, 16'd0);
        send_event(OP_RECEIVE_REPLY, 4'd0, 16'd0);
        send_event(OP_RECEIVE_REPLY, 4'd1, 16'd0);
        send_event(OP_RECEIVE_REPLY, 4'd3, base);
        send_event(OP_RECEIVE_REQUEST, 4'd1, 16'd0);         // held while inside
        send_event(OP_RELEASE, 4'd0, 16'd0);
        send_event(OP_RELEASE, 4'd0, 16'd0);                 // nothing left to answer
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RECEIVE_REQUEST, 4'd3, base + 16'd200);
        send_event(OP_RELEASE, 4'd0, 16'd0);                 // gives up before entering
        send_event(OP_RECEIVE_REPLY, 4'd0, 16'd0);           // late reply, no enter
    endtask

    // The receiver stops for a long while as full fan-outs pile up, so the job
    // queue fills and the input must stall; then the sender waits for the tail.
    task automatic test_backpressure();
        set_config(4'd0, 5'd16);
        rx_hold = 300;
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RECEIVE_REQUEST, 4'd5, node_clock + 16'd100);
        send_event(OP_RELEASE, 4'd0, 16'd0);
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RELEASE, 4'd0, 16'd0);
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RELEASE, 4'd0, 16'd0);
        wait_drain();
    endtask

    // One well-formed round: ask everyone, collect the replies in random order
    // with competing requests and noise mixed in, then leave. Some rounds give
    // up early.
    task automatic run_round();
        int others[$];
        int n;
        int r;
        int k;
        int tmp;
        n = (cfg_count > 5'd16) ? 16 : int'(cfg_count);
        for (int i = 0; i < n; i++) begin
            if (i != int'(cfg_own)) others.push_back(i);
        end
        for (int i = others.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = others[i];
            others[i] = others[k];
            others[k] = tmp;
        end

        send_event(OP_REQUEST, 4'($urandom), 16'($urandom));
        foreach (others[i]) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_event(OP_RECEIVE_REQUEST, 4'($urandom_range(0, n > 0 ? n - 1 : 0)),
                           stamp_near());
            end else if (r < 32) begin
                send_event(opcode_t'($urandom_range(0, 3)), 4'($urandom), stamp_near());
            end
            if (r >= 95) begin
                send_event(OP_RELEASE, 4'($urandom), 16'($urandom));
                return;
            end
            send_event(OP_RECEIVE_REPLY, 4'(others[i]), stamp_near());
        end
        repeat ($urandom_range(0, 2)) begin
            send_event(OP_RECEIVE_REQUEST, 4'($urandom_range(0, 15)), stamp_near());
        end
        send_event(OP_RELEASE, 4'($urandom), 16'($urandom));
    endtask

    task automatic test_random_rounds();
        logic [3:0] owns[6];
        logic [4:0] counts[6];
        int quota;
        owns   = '{4'd0, 4'd15, 4'd7, 4'd15, 4'($urandom), 4'($urandom)};
        counts = '{5'd16, 5'd16, 5'd2, 5'd31, 5'($urandom_range(2, 16)),
                   5'($urandom_range(2, 16))};
        for (int p = 0; p < 6; p++) begin
            set_config(owns[p], counts[p]);
            steady = (p == 2);
            quota = items_sent + 22;
            while (items_sent < quota) run_round();
        end
        steady = 1'b0;
    endtask

    // Saturation is final: the clock never comes down again, so this goes last.
    task automatic test_clock_saturation();
        set_config(4'd1, 5'd16);
        send_event(OP_RECEIVE_REQUEST, 4'd0, 16'hFFFF);
        send_event(OP_RECEIVE_REQUEST, 4'd3, 16'hFFFE);
        send_event(OP_REQUEST, 4'd0, 16'd0);
        send_event(OP_RECEIVE_REPLY, 4'd0, 16'hFFFF);
        send_event(OP_RELEASE, 4'd0, 16'd0);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        err_count = 0;
        items_sent = 0;
        rx_hold   = 0;
        steady    = 1'b0;

        // Mirror starts from the node's reset state.
        cfg_own       = 4'd0;
        cfg_count     = NODE_COUNT_RESET;
        node_clock    = '0;
        own_req_stamp = '0;
        want_cs       = 1'b0;
        in_cs         = 1'b0;
        deferred_bits = '0;
        awaited_bits  = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_lone_node();
        test_priority_and_deferral();
        test_backpressure();
        test_random_rounds();
        test_clock_saturation();

        wait_drain();
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/mrrn_pkg.sv
hw/rtl/mrrn_front.sv
hw/rtl/mrrn_queue.sv
hw/rtl/mrrn_back.sv
hw/rtl/mutex_request_reply_node.sv
tb/tb_top.sv
